>>> rtl/idcp_pkg.sv
// idcp_pkg: shared types and constants for the increasing digit combination printer
// no dependencies; used by the text channel interface, the digit cell and the top level
`timescale 1ns / 1ps
`default_nettype none

package idcp_pkg;

	// field widths
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned COUNT_W = 4;
	localparam int unsigned CHAR_W  = 6;

	// decimal radix and the top-of-range arithmetic width
	localparam int unsigned DECIMAL_BASE = 10;
	localparam int unsigned SUM_W        = 5;

	// digit count after reset
	localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd3;

	// ascii codes, low six bits
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'h30;
	localparam logic [CHAR_W-1:0] CHAR_COMMA = 6'h2C;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 6'h20;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [CHAR_W-1:0]  char_t;

	// control shared by every cell of the digit ring
	typedef struct packed {
		logic load_init;
		logic shift;
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/idcp_req_if.sv
// idcp_req_if: request channel, valid/ready with the restart bit
// depends on idcp_pkg for nothing but house conventions
`timescale 1ns / 1ps
`default_nettype none

interface idcp_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

>>> rtl/idcp_txt_if.sv
// idcp_txt_if: text channel, one character per transfer
// depends on idcp_pkg for the character type
`timescale 1ns / 1ps
`default_nettype none

interface idcp_txt_if;
	logic               valid;
	logic               ready;
	idcp_pkg::char_t    text_char;
	logic               last_of_run;
	logic               final_combination;

	modport source (output valid, output text_char, output last_of_run,
		output final_combination, input ready);
	modport sink (input valid, input text_char, input last_of_run,
		input final_combination, output ready);
endinterface

`default_nettype wire

>>> rtl/idcp_cell.sv
// idcp_cell: one digit position of the combination ring
// depends on idcp_pkg; holds one digit, shifts toward the head, flags its top value
`timescale 1ns / 1ps
`default_nettype none

module idcp_cell #(
	parameter int unsigned INDEX = 0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire idcp_pkg::cell_ctl_t ctl,
	input  wire idcp_pkg::count_t    k,
	input  wire idcp_pkg::digit_t    right_d,
	input  wire idcp_pkg::digit_t    wrap_d,
	output idcp_pkg::digit_t         d,
	output logic                     sat
);

	idcp_pkg::digit_t d_q;
	logic in_ring;
	logic is_tail;

	// ring membership and the tail position that takes the updated head digit
	assign in_ring = k > idcp_pkg::COUNT_W'(INDEX);
	assign is_tail = k == idcp_pkg::COUNT_W'(INDEX + 1);

	// digit holds its highest legal value for this position
	assign sat = {1'b0, d_q} ==
		(idcp_pkg::SUM_W'(idcp_pkg::DECIMAL_BASE) - {1'b0, k} + idcp_pkg::SUM_W'(INDEX));

	assign d = d_q;

	// digit register: ascending start value, or shift along the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= idcp_pkg::DIGIT_W'(INDEX);
		end else if (ctl.load_init) begin
			d_q <= idcp_pkg::DIGIT_W'(INDEX);
		end else if (ctl.shift && in_ring) begin
			d_q <= is_tail ? wrap_d : right_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/increasing_digit_combination_printer.sv
// increasing_digit_combination_printer: top level, request sequencer and digit ring
// depends on idcp_pkg, idcp_req_if, idcp_txt_if and idcp_cell
//
//   channel   dir  handshake          payload
//   req       in   valid/ready        restart
//   text      out  valid/ready        text_char, last_of_run, final_combination
//   cfg       in   cfg_we             cfg_wdata (digit_count)
//
// a request emits n characters (0, k, or k+2): the sequencer takes the request, finds the
// advancing digit, then sends the characters one after another.
// the ring of cells rotates once per request through its head cell, which forms each digit.
// reset, configuration writes and restart requests restore the ascending start digits at once, no sweep.
// a stalled text transfer holds the output register and the sequencer waits on it.
`timescale 1ns / 1ps
`default_nettype none

module increasing_digit_combination_printer #(
	parameter int unsigned MAX_DIGITS = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	idcp_req_if.sink               req,
	idcp_txt_if.source             text,
	input  wire logic              cfg_we,
	input  wire idcp_pkg::count_t  cfg_wdata
);

	localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_COMMA,
		ST_SPACE,
		ST_DIGITS
	} state_t;

	state_t              state_q;
	idcp_pkg::count_t    k_q;
	logic                started_q;
	logic                finished_q;
	logic                adv_q;
	logic                fin_q;
	logic [IDX_W-1:0]    pivot_q;
	logic [IDX_W-1:0]    pos_q;
	idcp_pkg::digit_t    prev_q;
	logic                out_valid_q;
	idcp_pkg::char_t     out_char_q;
	logic                out_last_q;
	logic                out_fin_q;

	idcp_pkg::digit_t    cell_d [MAX_DIGITS];
	logic [MAX_DIGITS-1:0] cell_sat;
	idcp_pkg::cell_ctl_t cell_ctl;

	logic                req_xfer;
	logic                out_free;
	logic                k_ok;
	logic [IDX_W-1:0]    piv;
	idcp_pkg::digit_t    d0_next;
	logic                fin;
	idcp_pkg::digit_t    nv;
	logic                last_digit;

	// handshakes
	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign out_free  = !out_valid_q || text.ready;

	assign text.valid             = out_valid_q;
	assign text.text_char         = out_char_q;
	assign text.last_of_run       = out_last_q;
	assign text.final_combination = out_fin_q;

	// ring control
	assign cell_ctl.load_init = cfg_we || (req_xfer && req.restart);
	assign cell_ctl.shift     = (state_q == ST_DIGITS) && out_free;

	// row of digit cells, head at index zero
	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		idcp_pkg::digit_t right_d;
		if (i + 1 < MAX_DIGITS) begin : g_mid
			assign right_d = cell_d[i+1];
		end else begin : g_end
			assign right_d = '0;
		end
		idcp_cell #(.INDEX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl),
			.k       (k_q),
			.right_d (right_d),
			.wrap_d  (nv),
			.d       (cell_d[i]),
			.sat     (cell_sat[i])
		);
	end

	// digit count in range
	assign k_ok = (k_q != '0) && (k_q <= idcp_pkg::COUNT_W'(MAX_DIGITS));

	// advancing position: highest active cell not yet at its top value
	always_comb begin
		piv = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if ((idcp_pkg::COUNT_W'(i) < k_q) && !cell_sat[i]) begin
				piv = IDX_W'(i);
			end
		end
	end

	// the new combination is the last one when its first digit is ten minus k
	assign d0_next = (started_q && (piv == '0)) ? (cell_d[0] + 4'd1) : cell_d[0];
	assign fin = {1'b0, d0_next} ==
		(idcp_pkg::SUM_W'(idcp_pkg::DECIMAL_BASE) - {1'b0, k_q});

	// head digit update as it passes out of the ring
	always_comb begin
		if (!adv_q || (pos_q < pivot_q)) begin
			nv = cell_d[0];
		end else if (pos_q == pivot_q) begin
			nv = cell_d[0] + 4'd1;
		end else begin
			nv = prev_q + 4'd1;
		end
	end

	assign last_digit = idcp_pkg::COUNT_W'(pos_q) == (k_q - idcp_pkg::COUNT_W'(1));

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= idcp_pkg::COUNT_RESET;
			started_q   <= 1'b0;
			finished_q  <= 1'b0;
			adv_q       <= 1'b0;
			fin_q       <= 1'b0;
			pivot_q     <= '0;
			pos_q       <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
			out_fin_q   <= 1'b0;
		end else begin
			if (out_valid_q && text.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_we) begin
						k_q        <= cfg_wdata;
						started_q  <= 1'b0;
						finished_q <= 1'b0;
					end
					if (req_xfer) begin
						if (req.restart) begin
							started_q  <= 1'b0;
							finished_q <= 1'b0;
						end
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (!k_ok || finished_q) begin
						state_q <= ST_IDLE;
					end else begin
						adv_q      <= started_q;
						pivot_q    <= piv;
						fin_q      <= fin;
						started_q  <= 1'b1;
						finished_q <= fin;
						pos_q      <= '0;
						state_q    <= started_q ? ST_COMMA : ST_DIGITS;
					end
				end
				ST_COMMA: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= idcp_pkg::CHAR_COMMA;
						out_last_q  <= 1'b0;
						out_fin_q   <= fin_q;
						state_q     <= ST_SPACE;
					end
				end
				ST_SPACE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= idcp_pkg::CHAR_SPACE;
						out_last_q  <= 1'b0;
						out_fin_q   <= fin_q;
						state_q     <= ST_DIGITS;
					end
				end
				ST_DIGITS: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= idcp_pkg::CHAR_ZERO + {2'b00, nv};
						out_last_q  <= last_digit;
						out_fin_q   <= fin_q;
						prev_q      <= nv;
						pos_q       <= pos_q + IDX_W'(1);
						if (last_digit) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// the last combination can only follow the first
	a_finished_started: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> started_q)
		else $error("finished set without a started sequence");

	// digit position stays inside the active ring
	a_pos_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGITS) |-> (idcp_pkg::COUNT_W'(pos_q) < k_q))
		else $error("digit position beyond the digit count");

	// a restart request reopens the sequence
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(req_xfer && req.restart) |=> (!finished_q && !started_q))
		else $error("restart did not clear the sequence flags");

	// a run marks its last character only on a digit
	a_last_on_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_char_q != idcp_pkg::CHAR_COMMA)
			&& (out_char_q != idcp_pkg::CHAR_SPACE))
		else $error("run ended on a separator");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// tb_top: self-checking bench for the increasing digit combination printer
// depends on idcp_pkg, idcp_req_if, idcp_txt_if and the printer top level
// directed table first, then random request phases checked against an in-bench predictor
`timescale 1ns / 1ps

module tb_top;

	localparam int MAX_DIGITS = 10;
	localparam int TXT_BYTES = 12;
	localparam int TXT_W = 8 * TXT_BYTES;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 200;
	localparam int RANDOM_RUNS = 107;
	localparam int MAX_REPORTS = 10;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	// one directed step: a request, or a digit count write
	typedef struct packed {
		row_kind_t        kind;
		idcp_pkg::count_t count;
		logic             restart;
		logic             typed;
		logic             fin;
		logic [TXT_W-1:0] txt;
	} row_t;

	typedef struct packed {
		idcp_pkg::char_t ch;
		logic            last;
		logic            fin;
	} text_beat_t;

	localparam int N_ROWS = 27;
	localparam row_t DIRECTED_ROWS [N_ROWS] = '{
		'{ROW_REQ, 4'd0, 1'b0, 1'b1, 1'b0, "012"},
		'{ROW_REQ, 4'd0, 1'b0, 1'b0, 1'b0, ""},
		'{ROW_REQ, 4'd0, 1'b1, 1'b1, 1'b0, "012"},
		'{ROW_CFG, 4'd10, 1'b0, 1'b0, 1'b0, ""},
		'{ROW_REQ, 4'd0, 1'b0, 1'b1, 1'b1, "0123456789"},
		'{ROW_REQ, 4'd0, 1'b0, 1'b1, 1'b0, ""},
		'{ROW_REQ, 4'd0, 1'b1, 1'b1, 1'b1, "0123456789"},
		'{ROW_CFG, 4'd1, 1'b0, 1'b0, 1'b0, ""},
		'{ROW_REQ, 4'd0, 1'b0, 1'b1, 1'b0, "0"},
		'{ROW_REQ, 4'd0, 1'b0, 1'b0, 1'b0, ""},
		'{ROW_REQ, 4'd0, 1'b0, 1'b0, 1'b0, ""},
		'{ROW_REQ, 4'd0, 1'b0, 1'b0, 1'b0, ""},
		'{ROW_REQ, 4'd0, 1'b0, 1'b0, 1'b0, ""},
		'{ROW_REQ, 4'd0, 1'b0, 1'b0, 1'b0, ""},
		'{ROW_REQ, 4'd0, 1'b0, 1'b0, 1'b0, ""},
		'{ROW_REQ, 4'd0, 1'b0, 1'b0, 1'b0, ""},
		'{ROW_REQ, 4'd0, 1'b0, 1'b0, 1'b0, ""},
		'{ROW_REQ, 4'd0, 1'b0, 1'b0, 1'b0, ""},
		'{ROW_REQ, 4'd0, 1'b0, 1'b1, 1'b0, ""},
		'{ROW_CFG, 4'd0, 1'b0, 1'b0, 1'b0, ""},
		'{ROW_REQ, 4'd0, 1'b0, 1'b1, 1'b0, ""},
		'{ROW_REQ, 4'd0, 1'b1, 1'b1, 1'b0, ""},
		'{ROW_CFG, 4'd15, 1'b0, 1'b0, 1'b0, ""},
		'{ROW_REQ, 4'd0, 1'b0, 1'b1, 1'b0, ""},
		'{ROW_CFG, 4'd9, 1'b0, 1'b0, 1'b0, ""},
		'{ROW_REQ, 4'd0, 1'b0, 1'b1, 1'b0, "012345678"},
		'{ROW_REQ, 4'd0, 1'b0, 1'b0, 1'b0, ""}
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	idcp_pkg::count_t cfg_wdata;

	idcp_req_if req ();
	idcp_txt_if text ();

	increasing_digit_combination_printer #(
		.MAX_DIGITS(MAX_DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.text(text),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// predictor state: count, current digits, progress flags
	idcp_pkg::count_t digit_count_q;
	idcp_pkg::digit_t seq_digit [MAX_DIGITS];
	logic             seq_started;
	logic             seq_finished;
	text_beat_t       run_text [$];
	text_beat_t       pending_text [$];

	int mismatches = 0;
	bit no_gaps = 1'b0;
	bit hold_pending = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// back to the first combination 0,1,2,...
	function automatic void clear_sequence();
		int i;
		for (i = 0; i < MAX_DIGITS; i++)
			seq_digit[i] = idcp_pkg::digit_t'(i);
		seq_started = 1'b0;
		seq_finished = 1'b0;
	endfunction

	// next combination as characters into run_text, returns its length
	function automatic int step_combination(input logic rst);
		int k;
		int i;
		int j;
		logic moved;
		logic fin;
		text_beat_t beat;
		run_text.delete();
		if (rst)
			clear_sequence();
		k = int'(digit_count_q);
		if (k < 1 || k > MAX_DIGITS || seq_finished)
			return 0;
		// bump the rightmost digit that still has room, refill to its right
		if (seq_started) begin
			moved = 1'b0;
			for (i = k - 1; i >= 0; i--) begin
				if (!moved && int'(seq_digit[i]) < int'(idcp_pkg::DECIMAL_BASE) - k + i) begin
					seq_digit[i] = seq_digit[i] + idcp_pkg::digit_t'(1);
					for (j = i + 1; j < k; j++)
						seq_digit[j] = seq_digit[j-1] + idcp_pkg::digit_t'(1);
					moved = 1'b1;
				end
			end
		end
		// last combination is the top k digits
		fin = 1'b1;
		for (i = 0; i < k; i++)
			if (int'(seq_digit[i]) != int'(idcp_pkg::DECIMAL_BASE) - k + i)
				fin = 1'b0;
		beat.last = 1'b0;
		beat.fin = fin;
		if (seq_started) begin
			beat.ch = idcp_pkg::CHAR_COMMA;
			run_text.push_back(beat);
			beat.ch = idcp_pkg::CHAR_SPACE;
			run_text.push_back(beat);
		end
		for (i = 0; i < k; i++) begin
			beat.ch = idcp_pkg::CHAR_ZERO + idcp_pkg::char_t'(seq_digit[i]);
			run_text.push_back(beat);
		end
		run_text[run_text.size()-1].last = 1'b1;
		seq_started = 1'b1;
		if (fin)
			seq_finished = 1'b1;
		return run_text.size();
	endfunction

	// one request transfer; typed text overrides the predicted run
	task automatic send_request(input logic rst, input logic typed, input logic [TXT_W-1:0] txt,
			input logic fin, output int n);
		text_beat_t beat;
		int b;
		@(negedge clk);
		while (!no_gaps && $urandom_range(0, 99) < 29) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.restart <= rst;
		do @(posedge clk); while (!req.ready);
		n = step_combination(rst);
		if (typed) begin
			run_text.delete();
			for (b = TXT_BYTES - 1; b >= 0; b--) begin
				if (txt[8*b +: 8] != 8'd0) begin
					beat.ch = idcp_pkg::char_t'(txt[8*b +: 8]);
					beat.last = 1'b0;
					beat.fin = fin;
					run_text.push_back(beat);
				end
			end
			if (run_text.size() != 0)
				run_text[run_text.size()-1].last = 1'b1;
			n = run_text.size();
		end
		foreach (run_text[i])
			pending_text.push_back(run_text[i]);
	endtask

	// digit count write, only once the block has drained
	task automatic write_digit_count(input idcp_pkg::count_t value);
		@(negedge clk);
		req.valid <= 1'b0;
		while (pending_text.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		digit_count_q = value;
		clear_sequence();
	endtask

	task automatic report_error(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s", $realtime, what);
	endtask

	// text sink: random stalls, a quiet stretch, and one long hold-off
	initial begin : text_sink
		int hold_left;
		hold_left = 0;
		text.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				text.ready <= 1'b0;
			end else if (no_gaps) begin
				text.ready <= 1'b1;
			end else begin
				text.ready <= ($urandom_range(0, 99) >= 29);
			end
		end
	end

	// compare every text transfer with the oldest expected character
	always @(posedge clk) begin : text_check
		text_beat_t want;
		if (arst_n && text.valid && text.ready) begin
			if (pending_text.size() == 0) begin
				report_error($sformatf("unexpected char %h last %b final %b",
					text.text_char, text.last_of_run, text.final_combination));
			end else begin
				want = pending_text.pop_front();
				if (text.text_char !== want.ch || text.last_of_run !== want.last ||
						text.final_combination !== want.fin)
					report_error($sformatf(
						"expected char %h last %b final %b, got char %h last %b final %b",
						want.ch, want.last, want.fin, text.text_char, text.last_of_run,
						text.final_combination));
			end
		end
	end

	// stimulus: reset, directed table, random phases, drain
	initial begin : stimulus
		int n;
		int total_out;
		int phase_items;
		int phase_out;
		idcp_pkg::count_t cnt;
		logic rst;
		bit held;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.restart = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		digit_count_q = idcp_pkg::COUNT_RESET;
		clear_sequence();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (DIRECTED_ROWS[r]) begin
			if (DIRECTED_ROWS[r].kind == ROW_CFG)
				write_digit_count(DIRECTED_ROWS[r].count);
			else
				send_request(DIRECTED_ROWS[r].restart, DIRECTED_ROWS[r].typed,
					DIRECTED_ROWS[r].txt, DIRECTED_ROWS[r].fin, n);
		end

		// random phases, each with a fresh digit count
		total_out = 0;
		held = 1'b0;
		while (total_out < RANDOM_RUNS) begin
			if ($urandom_range(0, 3) == 0)
				cnt = idcp_pkg::count_t'($urandom_range(0, 15));
			else
				cnt = idcp_pkg::count_t'($urandom_range(1, MAX_DIGITS));
			write_digit_count(cnt);
			phase_items = 0;
			phase_out = 0;
			while (phase_items < 40 && phase_out < 24 && total_out < RANDOM_RUNS &&
					!(phase_items >= 3 && (cnt == 0 || int'(cnt) > MAX_DIGITS))) begin
				// mostly stepping forward, restarting often once exhausted
				if (seq_finished)
					rst = logic'($urandom_range(0, 1));
				else
					rst = ($urandom_range(0, 99) < 5);
				no_gaps = (total_out >= 50 && total_out < 80);
				if (!held && total_out >= 20) begin
					held = 1'b1;
					hold_pending = 1'b1;
				end
				send_request(rst, 1'b0, '0, 1'b0, n);
				phase_items++;
				total_out++;
				if (n > 0)
					phase_out++;
			end
		end
		no_gaps = 1'b0;

		// drain
		@(negedge clk);
		req.valid <= 1'b0;
		while (pending_text.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		if (mismatches == 0 && pending_text.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> files.f
rtl/idcp_pkg.sv
rtl/idcp_req_if.sv
rtl/idcp_txt_if.sv
rtl/idcp_cell.sv
rtl/increasing_digit_combination_printer.sv
dv/tb_top.sv
